### design/tmd_pkg.sv
// ----------------------------------------------------------------------------
// tmd_pkg
// shared types and constants of the tape manchester decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tmd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned SyncW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned HeldW    = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [SyncW-1:0]   SyncEdgesReset = 8'd16;
  localparam logic [PeriodW-1:0] TimeoutReset   = 16'd5000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSyncEdges = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTimeout   = 1'b1;

  // input command codes
  localparam logic CmdEdge = 1'b0;
  localparam logic CmdPoll = 1'b1;

  // result kind codes
  localparam logic KindData     = 1'b0;
  localparam logic KindFinished = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] cycle_time;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  data_byte;
    logic [CountW-1:0] count;
  } out_word_t;

  typedef struct packed {
    logic [SyncW-1:0]   sync_edges;
    logic [PeriodW-1:0] timeout_cycles;
  } cfg_t;

endpackage

`default_nettype wire

### design/tmd_decode.sv
// ----------------------------------------------------------------------------
// tmd_decode
// decoder state and combinational step: timeout, sync training, pulse
// classification and byte assembly
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_decode (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fire_i,
  input  tmd_pkg::in_word_t   word_i,
  input  tmd_pkg::cfg_t       cfg_i,
  output logic                res_valid_o,
  output tmd_pkg::out_word_t  res_o
);
  import tmd_pkg::*;

  logic [TimeW-1:0]   last_q, last_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [SyncW-1:0]   sync_left_q, sync_left_d;
  logic               receiving_q, receiving_d;
  logic               half_phase_q, half_phase_d;
  logic               cur_bit_q, cur_bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic [CountW-1:0]  bytes_q, bytes_d;

  logic [TimeW-1:0]   t;
  logic [PeriodW-1:0] t16;
  logic               timed_out;
  logic [PeriodW-1:0] half;
  logic [PeriodW:0]   p_plus_half;
  logic [PeriodW+1:0] p_x3;
  logic [PeriodW:0]   sum_short;
  logic [PeriodW:0]   sum_long;
  logic               too_short;
  logic               sync_bad;
  logic               dec_bad;
  logic               is_long;
  logic               do_shift;
  logic [ByteW-1:0]   shifted;

  assign t           = word_i.cycle_time - last_q;
  assign t16         = t[PeriodW-1:0];
  assign timed_out   = t > {{(TimeW-PeriodW){1'b0}}, cfg_i.timeout_cycles};
  assign half        = {1'b0, period_q[PeriodW-1:1]};
  assign p_plus_half = {1'b0, period_q} + {1'b0, half};
  assign p_x3        = {2'b00, period_q} + {1'b0, period_q, 1'b0};
  assign sum_short   = {1'b0, period_q} + {1'b0, t16};
  assign sum_long    = {1'b0, period_q} + {2'b00, t16[PeriodW-1:1]};
  assign too_short   = t16 < half;
  assign sync_bad    = too_short || ({1'b0, t16} > p_plus_half);
  assign dec_bad     = too_short || ({2'b00, t16} > p_x3);
  assign is_long     = {1'b0, t16} >= p_plus_half;

  always_comb begin
    last_d       = last_q;
    period_d     = period_q;
    sync_left_d  = sync_left_q;
    receiving_d  = receiving_q;
    half_phase_d = half_phase_q;
    cur_bit_d    = cur_bit_q;
    shift_d      = shift_q;
    held_d       = held_q;
    bytes_d      = bytes_q;
    do_shift     = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (fire_i) begin
      if (word_i.cmd == CmdPoll) begin
        if (receiving_q && timed_out) begin
          receiving_d     = 1'b0;
          res_valid_o     = 1'b1;
          res_o.kind      = KindFinished;
          res_o.data_byte = '0;
          res_o.count     = bytes_q;
        end
      end else begin
        last_d = word_i.cycle_time;
        if (timed_out) begin
          sync_left_d = cfg_i.sync_edges;
          receiving_d = 1'b0;
        end else if (sync_left_q != '0) begin
          if (sync_bad) begin
            period_d    = t16;
            sync_left_d = cfg_i.sync_edges;
            receiving_d = 1'b0;
          end else begin
            period_d    = sum_short[PeriodW:1];
            sync_left_d = sync_left_q - 1'b1;
          end
        end else if (dec_bad) begin
          period_d    = t16;
          sync_left_d = cfg_i.sync_edges;
          receiving_d = 1'b0;
        end else begin
          period_d = is_long ? sum_long[PeriodW:1] : sum_short[PeriodW:1];
          if (!receiving_q) begin
            if (is_long) begin
              cur_bit_d    = 1'b1;
              receiving_d  = 1'b1;
              half_phase_d = 1'b1;
              shift_d      = {{(ByteW-1){1'b0}}, 1'b1};
              held_d       = {{(HeldW-1){1'b0}}, 1'b1};
              bytes_d      = '0;
            end
          end else if (is_long) begin
            cur_bit_d    = ~cur_bit_q;
            half_phase_d = 1'b1;
            do_shift     = 1'b1;
          end else begin
            half_phase_d = ~half_phase_q;
            do_shift     = ~half_phase_q;
          end
        end
      end
    end

    // append the current bit, emit at a full byte
    shifted = {shift_q[ByteW-2:0], cur_bit_d};
    if (do_shift) begin
      if (held_q == HeldW'(ByteW - 1)) begin
        res_valid_o     = 1'b1;
        res_o.kind      = KindData;
        res_o.data_byte = shifted;
        res_o.count     = bytes_q;
        bytes_d         = bytes_q + 1'b1;
        shift_d         = '0;
        held_d          = '0;
      end else begin
        shift_d = shifted;
        held_d  = held_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= '0;
      period_q     <= '0;
      sync_left_q  <= SyncEdgesReset;
      receiving_q  <= 1'b0;
      half_phase_q <= 1'b0;
      cur_bit_q    <= 1'b0;
      shift_q      <= '0;
      held_q       <= '0;
      bytes_q      <= '0;
    end else begin
      last_q       <= last_d;
      period_q     <= period_d;
      sync_left_q  <= sync_left_d;
      receiving_q  <= receiving_d;
      half_phase_q <= half_phase_d;
      cur_bit_q    <= cur_bit_d;
      shift_q      <= shift_d;
      held_q       <= held_d;
      bytes_q      <= bytes_d;
    end
  end

  // bit counter never reaches a full byte
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < HeldW'(ByteW))
    else $error("bit count out of range");

  // a result only comes from a processed word
  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i)
    else $error("result without word");

  // any result is only produced during reception and ends or keeps it
  a_res_while_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> receiving_q)
    else $error("result outside reception");

  // finish drops reception
  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KindFinished) |=> !receiving_q)
    else $error("reception still active after finish");

endmodule

`default_nettype wire

### design/tape_manchester_decoder.sv
// ----------------------------------------------------------------------------
// tape_manchester_decoder
// cassette tape decoder working on edge timestamps and end-of-tape polls
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_ready_o   in_data_i  (cmd, cycle_time)
//  out      output     out_valid_o / out_ready_i out_data_o (kind, byte, count)
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  one word per cycle while the output register is not stalled; a word is
//  registered in the stage, then processed by the decoder step, and its
//  result lands in the output register
//  a stalled output register holds a full stage and drops in_ready_o
//  reset clears the decoder state, sync count loads 16, timeout loads 5000
// ----------------------------------------------------------------------------
`default_nettype none

module tape_manchester_decoder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  tmd_pkg::in_word_t                in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output tmd_pkg::out_word_t               out_data_o,
  input  wire                              cfg_we_i,
  input  wire  [tmd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [tmd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tmd_pkg::*;

  cfg_t      cfg_q;
  in_word_t  stage_q;
  logic      stage_valid_q;
  out_word_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      fire;
  logic      res_valid;
  out_word_t res;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = stage_valid_q && advance;
  assign in_ready_o  = !stage_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_edges     <= SyncEdgesReset;
      cfg_q.timeout_cycles <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSyncEdges: cfg_q.sync_edges     <= cfg_data_i[SyncW-1:0];
        RegTimeout:   cfg_q.timeout_cycles <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  tmd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (stage_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // a held stage word is not lost while the output stalls
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && !advance) |=> (stage_valid_q && $stable(stage_q)))
    else $error("stage word lost under stall");

  // the output register only loads from a processed word
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !fire) |=> !out_valid_q)
    else $error("result appeared without a word");

  // a pending result is never overwritten
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !fire)
    else $error("word processed while result pending");

endmodule

`default_nettype wire

### verif/tmd_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// tmd_scoreboard_pkg
// decoder state mirror and result scoreboard for the tape decoder bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmd_scoreboard_pkg;

  import tmd_pkg::*;

  class tape_scoreboard;
    logic [SyncW-1:0]   sync_cfg;
    logic [PeriodW-1:0] timeout_cfg;
    logic [TimeW-1:0]   last_edge;
    logic [PeriodW-1:0] period;
    logic [SyncW-1:0]   sync_left;
    logic               receiving;
    logic               half_phase;
    logic               cur_bit;
    logic [ByteW-1:0]   shift_byte;
    logic [HeldW-1:0]   bits_held;
    logic [CountW-1:0]  byte_count;
    out_word_t          due_words[$];
    int unsigned        errors;
    int unsigned        bytes_checked;
    int unsigned        ends_checked;

    function new();
      sync_cfg      = SyncEdgesReset;
      timeout_cfg   = TimeoutReset;
      last_edge     = '0;
      period        = '0;
      sync_left     = SyncEdgesReset;
      receiving     = 1'b0;
      half_phase    = 1'b0;
      cur_bit       = 1'b0;
      shift_byte    = '0;
      bits_held     = '0;
      byte_count    = '0;
      errors        = 0;
      bytes_checked = 0;
      ends_checked  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegSyncEdges) begin
        sync_cfg = data[SyncW-1:0];
      end else if (idx == RegTimeout) begin
        timeout_cfg = data;
      end
    endfunction

    function void reload(logic [TimeW-1:0] gap);
      period    = gap[PeriodW-1:0];
      sync_left = sync_cfg;
      receiving = 1'b0;
    endfunction

    function void shift_bit();
      out_word_t r;
      shift_byte = {shift_byte[ByteW-2:0], cur_bit};
      bits_held  = bits_held + 1'b1;
      if (bits_held >= 8) begin
        r.kind      = KindData;
        r.data_byte = shift_byte;
        r.count     = byte_count;
        due_words.push_back(r);
        byte_count = byte_count + 1'b1;
        shift_byte = '0;
        bits_held  = '0;
      end
    endfunction

    function void decode_word(in_word_t w);
      logic [TimeW-1:0] gap;
      logic [TimeW-1:0] p;
      logic [TimeW-1:0] half;
      logic [TimeW-1:0] nxt;
      logic             is_long;
      out_word_t        r;
      gap  = w.cycle_time - last_edge;
      p    = {{(TimeW-PeriodW){1'b0}}, period};
      half = p >> 1;
      if (w.cmd == CmdPoll) begin
        if (receiving && gap > timeout_cfg) begin
          receiving   = 1'b0;
          r.kind      = KindFinished;
          r.data_byte = '0;
          r.count     = byte_count;
          due_words.push_back(r);
        end
        return;
      end
      last_edge = w.cycle_time;
      if (gap > timeout_cfg) begin
        sync_left = sync_cfg;
        receiving = 1'b0;
        return;
      end
      if (sync_left != 0) begin
        if (gap < half || gap > p + half) begin
          reload(gap);
        end else begin
          nxt       = (p + gap) >> 1;
          period    = nxt[PeriodW-1:0];
          sync_left = sync_left - 1'b1;
        end
        return;
      end
      if (gap < half || gap > p * 3) begin
        reload(gap);
        return;
      end
      is_long = (gap >= p + half);
      if (is_long) begin
        nxt = (p + (gap >> 1)) >> 1;
      end else begin
        nxt = (p + gap) >> 1;
      end
      period = nxt[PeriodW-1:0];
      if (!receiving) begin
        // start pulse opens reception with a one bit already held
        if (is_long) begin
          cur_bit    = 1'b1;
          receiving  = 1'b1;
          half_phase = 1'b1;
          shift_byte = 8'd1;
          bits_held  = 4'd1;
          byte_count = '0;
        end
        return;
      end
      if (is_long) begin
        cur_bit    = ~cur_bit;
        half_phase = 1'b1;
        shift_bit();
      end else begin
        half_phase = ~half_phase;
        if (half_phase) begin
          shift_bit();
        end
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (got.kind == KindData) begin
        bytes_checked++;
      end else begin
        ends_checked++;
      end
      if (due_words.size() == 0) begin
        $error("unexpected word: kind %0d byte %0h count %0d",
               got.kind, got.data_byte, got.count);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

endpackage

### verif/tape_manchester_decoder_tb.sv
// ----------------------------------------------------------------------------
// tape_manchester_decoder_tb
// drives edge and poll words built from clean tape bursts and random noise
// under several sync and timeout settings, mirrors the decoder state and
// compares every decoded byte and end-of-tape report in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_manchester_decoder_tb;

  import tmd_pkg::*;
  import tmd_scoreboard_pkg::*;

  localparam int unsigned Limit        = 1000000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tape_scoreboard      board;
  logic [TimeW-1:0]    tape_now;
  logic                tx_bit;
  logic                calm     = 1'b0;
  logic                hold_req = 1'b0;
  int unsigned         words_sent    = 0;
  int unsigned         holds_done    = 0;
  int unsigned         settings_used = 0;
  int unsigned         cycles        = 0;

  tape_manchester_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_word);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 49) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [TimeW-1:0] jitter(int unsigned p);
    return p - p / 8 + $urandom_range(0, p / 4);
  endfunction

  // offer one word, hold it until taken, then maybe leave a gap
  task automatic push_cmd(logic cmd, logic [TimeW-1:0] t);
    in_word_t    w;
    int unsigned gap;
    w.cmd        = cmd;
    w.cycle_time = t;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    board.decode_word(w);
    words_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_edge(logic [TimeW-1:0] dt);
    tape_now = tape_now + dt;
    push_cmd(CmdEdge, tape_now);
  endtask

  // manchester bits, msb first: same bit is two short pulses, a change is one long
  task automatic send_bits(logic [31:0] bits, int unsigned n, int unsigned p);
    int i;
    for (i = n - 1; i >= 0; i--) begin
      if (bits[i] == tx_bit) begin
        send_edge(jitter(p));
        send_edge(jitter(p));
      end else begin
        send_edge(jitter(2 * p));
      end
      tx_bit = bits[i];
      if ($urandom_range(0, 15) == 0) begin
        push_cmd(CmdPoll, tape_now + $urandom_range(0, p));
      end
    end
  endtask

  task automatic send_burst(int unsigned p);
    int unsigned ending;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) != 0) begin
      send_edge(board.timeout_cfg + 1 + $urandom_range(0, 500));
    end
    repeat (board.sync_cfg + 2) send_edge(jitter(p));
    send_edge(jitter(2 * p));
    tx_bit = 1'b1;
    send_bits($urandom(), 7, p);
    repeat ($urandom_range(0, 3)) send_bits($urandom(), 8, p);
    if ($urandom_range(0, 1) == 1) begin
      send_bits($urandom(), $urandom_range(1, 7), p);
    end
    ending = $urandom_range(0, 4);
    case (ending)
      0, 1: begin
        push_cmd(CmdPoll, tape_now + $urandom_range(0, p));
        push_cmd(CmdPoll, tape_now + board.timeout_cfg + 1 + $urandom_range(0, 300));
      end
      2: begin
        // edge after the timeout ends reception without a report
        send_edge(board.timeout_cfg + 1 + $urandom_range(0, 300));
        push_cmd(CmdPoll, tape_now + board.timeout_cfg + 1 + $urandom_range(0, 300));
      end
      3: begin
        send_edge($urandom_range(0, p / 4));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_noise(int unsigned n, int unsigned same_pct);
    logic             cmd;
    logic [TimeW-1:0] t;
    int unsigned      k;
    repeat (n) begin
      cmd = ($urandom_range(0, 3) == 0) ? CmdPoll : CmdEdge;
      k   = $urandom_range(0, 99);
      if (k < same_pct) begin
        t = tape_now;
      end else if (k < same_pct + (100 - same_pct) / 2) begin
        t = tape_now + $urandom_range(1, 3000);
      end else begin
        t = $urandom();
      end
      if (cmd == CmdEdge) begin
        tape_now = t;
      end
      push_cmd(cmd, t);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [SyncW-1:0] sync, logic [CfgDataW-1:0] timeout);
    logic [CfgDataW-SyncW-1:0] junk;
    junk = $urandom_range(0, 255);
    write_reg(RegSyncEdges, {junk, sync});
    write_reg(RegTimeout, timeout);
    settings_used++;
  endtask

  task automatic run_phase(logic [SyncW-1:0] sync, logic [CfgDataW-1:0] timeout,
                           int unsigned pmax, int unsigned target);
    settle();
    set_config(sync, timeout);
    // noise-only phase also carries the long output stall
    if (pmax == 0) begin
      calm     = 1'b0;
      hold_req = 1'b1;
    end
    do begin
      if (pmax == 0) begin
        send_noise(8, 90);
      end else if ($urandom_range(0, 7) == 0) begin
        calm = 1'b0;
        send_noise($urandom_range(1, 12), 20);
      end else begin
        send_burst($urandom_range(4, pmax));
      end
    end while (words_sent < target);
  endtask

  initial begin
    logic [CfgDataW-1:0] tmo;
    board    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    tape_now = '0;
    tx_bit   = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes of the time field and both commands at reset settings
    push_cmd(CmdPoll, '0);
    push_cmd(CmdEdge, '0);
    push_cmd(CmdEdge, '1);
    push_cmd(CmdPoll, '1);
    push_cmd(CmdEdge, 32'd3);
    push_cmd(CmdEdge, 32'd7);
    tape_now = 32'd7;
    settle();
    set_config(8'd2, 16'd200);

    // one short clean byte 0xb2, then a poll too early and one past the timeout
    send_edge(32'd300);
    repeat (3) send_edge(32'd20);
    send_edge(32'd40);
    tx_bit = 1'b1;
    send_bits(32'h32, 7, 20);
    push_cmd(CmdPoll, tape_now + 32'd150);
    push_cmd(CmdPoll, tape_now + 32'd201);

    run_phase(SyncEdgesReset, TimeoutReset, 1000, 450);
    run_phase(8'd1, 16'hffff, 21000, 700);
    run_phase(8'd255, 16'd2000, 600, 1000);
    run_phase(8'd0, 16'd0, 0, 1200);
    tmo = $urandom_range(300, 65535);
    run_phase($urandom_range(1, 40), tmo, (tmo / 3 > 3000) ? 3000 : tmo / 3, 1380);
    tmo = $urandom_range(300, 65535);
    run_phase($urandom_range(1, 40), tmo, (tmo / 3 > 3000) ? 3000 : tmo / 3, 1550);
    settle();

    $display("%0d words sent under %0d register settings; %0d bytes and %0d end reports checked",
             words_sent, settings_used, board.bytes_checked, board.ends_checked);
    $display("output held off %0d time(s) for %0d cycles while input kept coming",
             holds_done, HoldCycles);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
